>>> src/mecanum_drive_command_mixer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mecanum drive command mixer
// Shorthand for clocked checks, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef MECANUM_DRIVE_COMMAND_MIXER_ASSERT_SVH
`define MECANUM_DRIVE_COMMAND_MIXER_ASSERT_SVH

// Check on every edge outside reset.
`define MDCM_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every edge, reset included.
`define MDCM_CHECK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/mdcm_pkg.sv
// ----------------------------------------------------------------------------
// mdcm_pkg
// Shared widths, command codes, trim constants, pivot tables and stage items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdcm_pkg;

  localparam int SPEED_W    = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int DPS_W      = 16;
  localparam int IRS_W      = 16;
  localparam int DPS_FRAC   = 8;
  localparam int W_W        = SPEED_W + 1;
  localparam int OM_W       = W_W + IRS_W + 1;
  localparam int OFS_W      = 12;
  localparam int PROD_W     = OM_W + OFS_W;
  localparam int TURN_SHIFT = 24;
  localparam int VEL_W      = PROD_W - TURN_SHIFT;
  localparam int WHEEL_W    = VEL_W + 2;
  localparam int SCALE_W    = 10;
  localparam int TRIM_W     = WHEEL_W + SCALE_W + 1;
  localparam int TRIM_FRAC  = 8;
  localparam int MAG_W      = TRIM_W - TRIM_FRAC;
  localparam int DPROD_W    = MAG_W + DPS_W;

  typedef enum logic [2:0] {
    CMD_STOP         = 3'd0,
    CMD_FORWARD      = 3'd1,
    CMD_REVERSE      = 3'd2,
    CMD_STRAFE_RIGHT = 3'd3,
    CMD_STRAFE_LEFT  = 3'd4,
    CMD_WHEEL_TEST   = 3'd5,
    CMD_TURN_LEFT    = 3'd6,
    CMD_TURN_RIGHT   = 3'd7
  } cmd_e;

  localparam logic [2:0] PIVOT_FRONT  = 3'd0;
  localparam logic [2:0] PIVOT_BACK   = 3'd1;
  localparam logic [2:0] PIVOT_LEFT   = 3'd2;
  localparam logic [2:0] PIVOT_RIGHT  = 3'd3;
  localparam logic [2:0] PIVOT_CENTER = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DUTY_PER_SPEED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ACTIVE_DUTY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY            = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_POLARITY_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_RADIUS_SUM  = 3'd4;

  // Per-wheel trims, Q.8
  localparam logic [SCALE_W-1:0] TRIM_UNITY        = 10'd256;
  localparam logic [SCALE_W-1:0] TRIM_DRIVE        = 10'd276;
  localparam logic [SCALE_W-1:0] TRIM_STRAFE_RIGHT = 10'd274;
  localparam logic [SCALE_W-1:0] TRIM_STRAFE_LEFT  = 10'd294;

  localparam logic [DPS_W-1:0] DPS_RESET = 16'd2560;
  localparam logic [IRS_W-1:0] IRS_RESET = 16'd6554;

  typedef struct packed {
    cmd_e                      cmd;
    logic signed [SPEED_W-1:0] speed;
    logic [2:0]                pivot;
    logic [3:0][SPEED_W-1:0]   test;
  } cmd_item_t;

  typedef struct packed {
    logic                      brake;
    logic                      test;
    logic                      turn;
    logic signed [W_W-1:0]     w;
    logic signed [OM_W-1:0]    om;
    logic signed [OFS_W-1:0]   tx;
    logic signed [OFS_W-1:0]   ty;
    logic signed [W_W-1:0]     vx0;
    logic signed [W_W-1:0]     vy0;
    logic [3:0][SCALE_W-1:0]   scale;
    logic [3:0][SPEED_W-1:0]   tw;
  } kin_s1_t;

  typedef struct packed {
    logic                      brake;
    logic                      test;
    logic                      turn;
    logic signed [W_W-1:0]     w;
    logic signed [PROD_W-1:0]  px;
    logic signed [PROD_W-1:0]  py;
    logic signed [W_W-1:0]     vx0;
    logic signed [W_W-1:0]     vy0;
    logic [3:0][SCALE_W-1:0]   scale;
    logic [3:0][SPEED_W-1:0]   tw;
  } kin_s2_t;

  typedef struct packed {
    logic                      brake;
    logic [3:0][WHEEL_W-1:0]   wheel;
    logic [3:0][SCALE_W-1:0]   scale;
  } wheel_item_t;

  typedef struct packed {
    logic                      brake;
    logic [3:0]                neg;
    logic [3:0][MAG_W-1:0]     mag;
  } mag_item_t;

  function automatic logic signed [OFS_W-1:0] pivot_x(input logic right,
                                                       input logic [2:0] pv);
    logic signed [OFS_W-1:0] r;
    r = '0;
    case (pv)
      PIVOT_FRONT:  r = right ? OFS_W'(179) : OFS_W'(0);
      PIVOT_BACK:   r = right ? OFS_W'(26) : OFS_W'(13);
      PIVOT_LEFT:   r = OFS_W'(-461);
      PIVOT_RIGHT:  r = OFS_W'(479);
      PIVOT_CENTER: r = right ? OFS_W'(205) : OFS_W'(-26);
      default:      r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [OFS_W-1:0] pivot_y(input logic right,
                                                       input logic [2:0] pv);
    logic signed [OFS_W-1:0] r;
    r = '0;
    case (pv)
      PIVOT_FRONT:  r = right ? OFS_W'(-1101) : OFS_W'(-1075);
      PIVOT_BACK:   r = OFS_W'(1088);
      PIVOT_CENTER: r = right ? OFS_W'(13) : OFS_W'(-64);
      default:      r = '0;
    endcase
    return r;
  endfunction

  // Shift right by TURN_SHIFT, rounding toward zero
  function automatic logic signed [VEL_W-1:0] shr_turn(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] t;
    t = x + (x[PROD_W-1] ? PROD_W'((64'd1 << TURN_SHIFT) - 64'd1) : '0);
    return t[PROD_W-1:TURN_SHIFT];
  endfunction

endpackage

>>> src/mecanum_drive_command_mixer.sv
// ----------------------------------------------------------------------------
// mecanum_drive_command_mixer: an accepted item passes the six register stages
// in order to the output register. Throughput one item per cycle unless
// out_ready stalls the output; each of the six register stages holds its own
// valid bit and takes a new item whenever it is empty or its successor moves.
// Reset (synchronous, high) empties every stage and restores the five configuration registers.
// Top level: mecanum X-drive inverse kinematics with per-command wheel trim.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mecanum_drive_command_mixer_assert.svh"

module mecanum_drive_command_mixer #(
  parameter int SPEED_FRAC_BITS = 8,
  parameter int DUTY_WIDTH      = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          cmd,
  input  logic signed [mdcm_pkg::SPEED_W-1:0] speed,
  input  logic [2:0]                          pivot,
  input  logic signed [mdcm_pkg::SPEED_W-1:0] test_front_left,
  input  logic signed [mdcm_pkg::SPEED_W-1:0] test_front_right,
  input  logic signed [mdcm_pkg::SPEED_W-1:0] test_rear_left,
  input  logic signed [mdcm_pkg::SPEED_W-1:0] test_rear_right,
  // duty channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [DUTY_WIDTH:0]          duty_front_left,
  output logic signed [DUTY_WIDTH:0]          duty_front_right,
  output logic signed [DUTY_WIDTH:0]          duty_rear_left,
  output logic signed [DUTY_WIDTH:0]          duty_rear_right,
  output logic                                brake,
  // register write port
  input  logic                                cfg_write,
  input  logic [mdcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mdcm_pkg::CFG_W-1:0]          cfg_data
);
  import mdcm_pkg::*;

  localparam int DUTY_LIMIT = (1 << DUTY_WIDTH) - 1;
  localparam int MAX_DUTY_RESET = (DUTY_LIMIT < 1000) ? DUTY_LIMIT : 1000;

  // Registers
  logic [DPS_W-1:0]      duty_per_speed;
  logic [DUTY_WIDTH-1:0] min_active_duty;
  logic [DUTY_WIDTH-1:0] max_duty;
  logic [3:0]            wheel_polarity_mask;
  logic [IRS_W-1:0]      inverse_radius_sum;

  // Inter-stage channels
  cmd_item_t   cmd_item;
  wheel_item_t wheel_item;
  mag_item_t   mag_item;
  logic        wheel_valid, wheel_ready;
  logic        mag_valid, mag_ready;
  logic signed [DUTY_WIDTH:0] duty [4];
  logic signed [DUTY_WIDTH:0] max_duty_s;

  // The user writes registers only while the pipeline is empty (the block does
  // not enforce it); all stages read them directly; unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_per_speed      <= DPS_RESET;
      min_active_duty     <= '0;
      max_duty            <= DUTY_WIDTH'(MAX_DUTY_RESET);
      wheel_polarity_mask <= '0;
      inverse_radius_sum  <= IRS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DUTY_PER_SPEED:      duty_per_speed      <= cfg_data[DPS_W-1:0];
        REG_MIN_ACTIVE_DUTY:     min_active_duty     <= cfg_data[DUTY_WIDTH-1:0];
        REG_MAX_DUTY:            max_duty            <= cfg_data[DUTY_WIDTH-1:0];
        REG_WHEEL_POLARITY_MASK: wheel_polarity_mask <= cfg_data[3:0];
        REG_INVERSE_RADIUS_SUM:  inverse_radius_sum  <= cfg_data[IRS_W-1:0];
        default: ;
      endcase
    end
  end

  // Gather the command item; wheel order is FL, FR, RL, RR throughout
  always_comb begin
    cmd_item.cmd     = cmd_e'(cmd);
    cmd_item.speed   = speed;
    cmd_item.pivot   = pivot;
    cmd_item.test[0] = test_front_left;
    cmd_item.test[1] = test_front_right;
    cmd_item.test[2] = test_rear_left;
    cmd_item.test[3] = test_rear_right;
  end

  // Stages 1 to 3: rotation products and wheel mix
  mdcm_kin u_kin (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_item            (cmd_item),
    .out_valid          (wheel_valid),
    .out_ready          (wheel_ready),
    .out_item           (wheel_item),
    .inverse_radius_sum (inverse_radius_sum)
  );

  // Stage 4: per-wheel trim, sign and magnitude
  mdcm_trim u_trim (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wheel_valid),
    .in_ready  (wheel_ready),
    .in_item   (wheel_item),
    .out_valid (mag_valid),
    .out_ready (mag_ready),
    .out_item  (mag_item)
  );

  // Stages 5 and 6: duty scaling, floor, clamp, polarity; stage 6 is the
  // output register, so an item waits there while upstream keeps filling
  mdcm_duty #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
    .DUTY_WIDTH      (DUTY_WIDTH)
  ) u_duty (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (mag_valid),
    .in_ready            (mag_ready),
    .in_item             (mag_item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .duty_per_speed      (duty_per_speed),
    .min_active_duty     (min_active_duty),
    .max_duty            (max_duty),
    .wheel_polarity_mask (wheel_polarity_mask),
    .duty                (duty),
    .brake               (brake)
  );

  assign duty_front_left  = duty[0];
  assign duty_front_right = duty[1];
  assign duty_rear_left   = duty[2];
  assign duty_rear_right  = duty[3];

  assign max_duty_s = $signed({1'b0, max_duty});

  // A braking result carries no drive on any wheel
  `MDCM_CHECK(a_brake_no_drive, out_valid && brake |-> duty_front_left == '0 && duty_front_right == '0 && duty_rear_left == '0 && duty_rear_right == '0, "brake with nonzero duty")
  // No wheel ever exceeds the clamp in either direction
  `MDCM_CHECK(a_clamp_front, out_valid |-> duty_front_left <= max_duty_s && duty_front_left >= -max_duty_s && duty_front_right <= max_duty_s && duty_front_right >= -max_duty_s, "front duty beyond max_duty")
  `MDCM_CHECK(a_clamp_rear, out_valid |-> duty_rear_left <= max_duty_s && duty_rear_left >= -max_duty_s && duty_rear_right <= max_duty_s && duty_rear_right >= -max_duty_s, "rear duty beyond max_duty")
  // Reset empties the pipeline
  `MDCM_CHECK_RST(a_reset_empty, rst |=> !out_valid, "result present after reset")

endmodule

>>> src/mdcm_kin.sv
// ----------------------------------------------------------------------------
// mdcm_kin
// Three-stage kinematics: turn rate and pivot products, then wheel mix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdcm_kin (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mdcm_pkg::cmd_item_t           in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mdcm_pkg::wheel_item_t         out_item,
  input  logic [mdcm_pkg::IRS_W-1:0]    inverse_radius_sum
);
  import mdcm_pkg::*;

  logic        v1, v2, v3;
  logic        rdy1, rdy2, rdy3;
  kin_s1_t     s1, s1_next;
  kin_s2_t     s2, s2_next;
  wheel_item_t s3, s3_next;

  logic                    right;
  logic signed [W_W-1:0]   sp;
  logic signed [VEL_W-1:0] vx_t, vy_t;
  logic signed [WHEEL_W-1:0] vx, vy, wx;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;
  assign out_item  = s3;

  // Stage 1: decode, turn rate times inverse radius sum, pivot lookup
  always_comb begin
    right = (in_item.cmd == CMD_TURN_RIGHT);
    sp    = W_W'(in_item.speed);
    s1_next.brake = (in_item.cmd == CMD_STOP);
    s1_next.test  = (in_item.cmd == CMD_WHEEL_TEST);
    s1_next.turn  = (in_item.cmd == CMD_TURN_LEFT) || right;
    s1_next.w     = s1_next.turn ? (right ? -sp : sp) : '0;
    s1_next.om    = OM_W'(s1_next.w * $signed({1'b0, inverse_radius_sum}));
    s1_next.tx    = pivot_x(right, in_item.pivot);
    s1_next.ty    = pivot_y(right, in_item.pivot);
    s1_next.vx0   = '0;
    s1_next.vy0   = '0;
    s1_next.scale = {4{TRIM_UNITY}};
    s1_next.tw    = in_item.test;
    case (in_item.cmd)
      CMD_FORWARD: begin
        s1_next.vy0      = sp;
        s1_next.scale[0] = TRIM_DRIVE;
        s1_next.scale[2] = TRIM_DRIVE;
      end
      CMD_REVERSE: begin
        s1_next.vy0      = -sp;
        s1_next.scale[0] = TRIM_DRIVE;
        s1_next.scale[2] = TRIM_DRIVE;
      end
      CMD_STRAFE_RIGHT: begin
        s1_next.vx0      = -sp;
        s1_next.scale[3] = TRIM_STRAFE_RIGHT;
      end
      CMD_STRAFE_LEFT: begin
        s1_next.vx0      = sp;
        s1_next.scale[0] = TRIM_STRAFE_LEFT;
      end
      default: ;
    endcase
  end

  // Stage 2: products with the pivot offsets
  always_comb begin
    s2_next.brake = s1.brake;
    s2_next.test  = s1.test;
    s2_next.turn  = s1.turn;
    s2_next.w     = s1.w;
    s2_next.px    = PROD_W'(s1.om * s1.tx);
    s2_next.py    = PROD_W'(s1.om * s1.ty);
    s2_next.vx0   = s1.vx0;
    s2_next.vy0   = s1.vy0;
    s2_next.scale = s1.scale;
    s2_next.tw    = s1.tw;
  end

  // Stage 3: truncate the turn terms and mix the four wheels
  always_comb begin
    vx_t = shr_turn(s2.py);
    vy_t = -shr_turn(s2.px);
    vx   = s2.turn ? WHEEL_W'(vx_t) : WHEEL_W'(s2.vx0);
    vy   = s2.turn ? WHEEL_W'(vy_t) : WHEEL_W'(s2.vy0);
    wx   = WHEEL_W'(s2.w);
    s3_next.brake = s2.brake;
    s3_next.scale = s2.scale;
    if (s2.test) begin
      for (int i = 0; i < 4; i++) begin
        s3_next.wheel[i] = WHEEL_W'($signed(s2.tw[i]));
      end
    end else begin
      s3_next.wheel[0] = vy - vx - wx;
      s3_next.wheel[1] = vy + vx + wx;
      s3_next.wheel[2] = vy + vx - wx;
      s3_next.wheel[3] = vy - vx + wx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1 <= s1_next;
    if (rdy2) s2 <= s2_next;
    if (rdy3) s3 <= s3_next;
  end

endmodule

>>> src/mdcm_trim.sv
// ----------------------------------------------------------------------------
// mdcm_trim
// One stage: apply the per-wheel trim and split each wheel into sign and size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdcm_trim (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mdcm_pkg::wheel_item_t in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mdcm_pkg::mag_item_t   out_item
);
  import mdcm_pkg::*;

  logic                     v1;
  logic                     rdy1;
  mag_item_t                s1, s1_next;
  logic signed [TRIM_W-1:0] prod [4];
  logic [TRIM_W-1:0]        absv [4];

  assign rdy1      = !v1 || out_ready;
  assign in_ready  = rdy1;
  assign out_valid = v1;
  assign out_item  = s1;

  // Truncating toward zero is a shift of the magnitude
  always_comb begin
    s1_next.brake = in_item.brake;
    for (int i = 0; i < 4; i++) begin
      prod[i] = $signed(in_item.wheel[i]) * $signed({1'b0, in_item.scale[i]});
      absv[i] = prod[i][TRIM_W-1] ? TRIM_W'(-prod[i]) : TRIM_W'(prod[i]);
      s1_next.neg[i] = prod[i][TRIM_W-1];
      s1_next.mag[i] = absv[i][TRIM_W-1:TRIM_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1 <= s1_next;
  end

endmodule

>>> src/mdcm_duty.sv
// ----------------------------------------------------------------------------
// mdcm_duty
// Two stages: scale by duty per speed, then floor, clamp and set direction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdcm_duty #(
  parameter int SPEED_FRAC_BITS = 8,
  parameter int DUTY_WIDTH      = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mdcm_pkg::mag_item_t           in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  logic [mdcm_pkg::DPS_W-1:0]    duty_per_speed,
  input  logic [DUTY_WIDTH-1:0]         min_active_duty,
  input  logic [DUTY_WIDTH-1:0]         max_duty,
  input  logic [3:0]                    wheel_polarity_mask,
  output logic signed [DUTY_WIDTH:0]    duty [4],
  output logic                          brake
);
  import mdcm_pkg::*;

  localparam int DUTY_SHIFT = SPEED_FRAC_BITS + DPS_FRAC;

  logic                     v1, v2;
  logic                     rdy1, rdy2;
  logic                     brake1;
  logic [3:0]               neg1;
  logic [DPROD_W-1:0]       dprod1 [4];
  logic [DPROD_W-1:0]       dprod_next [4];
  logic [DPROD_W-1:0]       d_full [4];
  logic [DPROD_W-1:0]       d_raised [4];
  logic [DPROD_W-1:0]       d_clamp [4];
  logic [DPROD_W-1:0]       min_ext, max_ext;
  logic [DUTY_WIDTH-1:0]    mag_final [4];
  logic signed [DUTY_WIDTH:0] duty_next [4];

  assign rdy2      = !v2 || out_ready;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dprod_next[i] = DPROD_W'(in_item.mag[i] * duty_per_speed);
    end
  end

  // Raise a moving wheel to the floor, then clamp; a zero duty stays zero
  always_comb begin
    min_ext = DPROD_W'(min_active_duty);
    max_ext = DPROD_W'(max_duty);
    for (int i = 0; i < 4; i++) begin
      d_full[i]    = dprod1[i] >> DUTY_SHIFT;
      d_raised[i]  = (d_full[i] != '0 && d_full[i] < min_ext) ? min_ext : d_full[i];
      d_clamp[i]   = (d_raised[i] > max_ext) ? max_ext : d_raised[i];
      mag_final[i] = d_clamp[i][DUTY_WIDTH-1:0];
      if (brake1) begin
        duty_next[i] = '0;
      end else if (neg1[i] ^ wheel_polarity_mask[i]) begin
        duty_next[i] = -$signed({1'b0, mag_final[i]});
      end else begin
        duty_next[i] = $signed({1'b0, mag_final[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      brake1 <= in_item.brake;
      neg1   <= in_item.neg;
      dprod1 <= dprod_next;
    end
    if (rdy2) begin
      brake <= brake1;
      duty  <= duty_next;
    end
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the mecanum drive command mixer
// Sends directed and random drive commands under several register settings,
// with random input gaps and output back-pressure, and scores every duty set
// against a typed answer or a bench-side mixer with the same trims and duty rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mdcm_pkg::*;

  localparam int DUTY_W     = 10;
  localparam int DUTY_SHIFT = 16;   // speed fraction bits plus the Q8.8 factor
  localparam int ROT_SHIFT  = 24;
  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 140;

  // Pivots beyond the named ones: these fall back to zero offsets
  localparam logic [2:0] PIVOT_OUT_LO = 3'd5;
  localparam logic [2:0] PIVOT_OUT_HI = 3'd7;

  // Per-wheel trims, Q.8
  localparam longint SCALE_ONE    = 256;
  localparam longint SCALE_FWD    = 276;
  localparam longint SCALE_SRIGHT = 274;
  localparam longint SCALE_SLEFT  = 294;

  // Pivot offsets in Q.8 inches, one table per turn direction
  localparam longint LEFT_X  [8] = '{0, 13, -461, 479, -26, 0, 0, 0};
  localparam longint LEFT_Y  [8] = '{-1075, 1088, 0, 0, -64, 0, 0, 0};
  localparam longint RIGHT_X [8] = '{179, 26, -461, 479, 205, 0, 0, 0};
  localparam longint RIGHT_Y [8] = '{-1101, 1088, 0, 0, 13, 0, 0, 0};

  typedef struct packed {
    cmd_e               op;
    logic signed [15:0] speed;
    logic [2:0]         pivot;
    logic signed [15:0] tfl;
    logic signed [15:0] tfr;
    logic signed [15:0] trl;
    logic signed [15:0] trr;
  } drive_cmd_t;

  typedef struct packed {
    logic signed [DUTY_W:0] fl;
    logic signed [DUTY_W:0] fr;
    logic signed [DUTY_W:0] rl;
    logic signed [DUTY_W:0] rr;
    logic                   brake;
  } duty_set_t;

  typedef struct packed {
    drive_cmd_t c;
    logic       typed;
    duty_set_t  want;
  } cmd_row_t;

  localparam duty_set_t NO_DUTY = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [2:0]                 cmd = '0;
  logic signed [SPEED_W-1:0]  speed = '0;
  logic [2:0]                 pivot = '0;
  logic signed [SPEED_W-1:0]  test_front_left = '0;
  logic signed [SPEED_W-1:0]  test_front_right = '0;
  logic signed [SPEED_W-1:0]  test_rear_left = '0;
  logic signed [SPEED_W-1:0]  test_rear_right = '0;

  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [DUTY_W:0]     duty_front_left;
  logic signed [DUTY_W:0]     duty_front_right;
  logic signed [DUTY_W:0]     duty_rear_left;
  logic signed [DUTY_W:0]     duty_rear_right;
  logic                       brake;

  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;

  // Travels alongside the payload: a typed row carries its own answer
  logic      row_typed = 1'b0;
  duty_set_t row_want = '0;

  // Bench copy of the register file
  logic [15:0] set_dps = DPS_RESET;
  logic [9:0]  set_min = '0;
  logic [9:0]  set_max = 10'd1000;
  logic [3:0]  set_pol = '0;
  logic [15:0] set_irs = IRS_RESET;

  duty_set_t duty_q[$];
  cmd_row_t  cmd_table[$];

  int n_sent     = 0;
  int n_checked  = 0;
  int n_faults   = 0;
  int n_settings = 1;
  int gap_odds   = 3;     // 0: no gaps, else one item in gap_odds is preceded by a gap
  bit quiet      = 1'b0;  // set for the closing stretch: no idling on either side

  mecanum_drive_command_mixer dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .speed            (speed),
    .pivot            (pivot),
    .test_front_left  (test_front_left),
    .test_front_right (test_front_right),
    .test_rear_left   (test_rear_left),
    .test_rear_right  (test_rear_right),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .duty_front_left  (duty_front_left),
    .duty_front_right (duty_front_right),
    .duty_rear_left   (duty_rear_left),
    .duty_rear_right  (duty_rear_right),
    .brake            (brake),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shift the magnitude and restore the sign, so negatives truncate toward zero
  function automatic longint trunc_shr(longint x, int s);
    longint m;
    m = (x < 0) ? -x : x;
    m = m >> s;
    return (x < 0) ? -m : m;
  endfunction

  // Turn one wheel speed into a signed duty under the current registers
  function automatic logic signed [DUTY_W:0] wheel_duty(longint v, int idx);
    longint                 mag;
    longint                 d;
    logic                   neg;
    logic signed [DUTY_W:0] dv;
    neg = (v < 0);
    mag = neg ? -v : v;
    d = (mag * longint'(set_dps)) >> DUTY_SHIFT;
    if (d > 0 && d < longint'(set_min))
      d = longint'(set_min);
    // clamp after the raise, so a minimum above the maximum still clamps
    if (d > longint'(set_max))
      d = longint'(set_max);
    if (set_pol[idx])
      neg = !neg;
    dv = (DUTY_W + 1)'(d);
    return neg ? -dv : dv;
  endfunction

  // Bench mixer: wheel kinematics, trims and duty conversion for one command
  function automatic duty_set_t mix_duties(drive_cmd_t c);
    longint    s;
    longint    vx;
    longint    vy;
    longint    w;
    longint    om;
    longint    sc [4];
    longint    wh [4];
    duty_set_t r;
    r  = NO_DUTY;
    s  = longint'(c.speed);
    vx = 0;
    vy = 0;
    w  = 0;
    sc = '{SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE};
    if (c.op == CMD_STOP) begin
      r.brake = 1'b1;
      return r;
    end
    if (c.op == CMD_WHEEL_TEST) begin
      wh[0] = longint'(c.tfl);
      wh[1] = longint'(c.tfr);
      wh[2] = longint'(c.trl);
      wh[3] = longint'(c.trr);
    end else begin
      case (c.op)
        CMD_FORWARD: begin
          vy = s;
          sc[0] = SCALE_FWD;
          sc[2] = SCALE_FWD;
        end
        CMD_REVERSE: begin
          vy = -s;
          sc[0] = SCALE_FWD;
          sc[2] = SCALE_FWD;
        end
        CMD_STRAFE_RIGHT: begin
          vx = -s;
          sc[3] = SCALE_SRIGHT;
        end
        CMD_STRAFE_LEFT: begin
          vx = s;
          sc[0] = SCALE_SLEFT;
        end
        CMD_TURN_LEFT: begin
          w  = s;
          om = w * longint'(set_irs);
          vx = trunc_shr(om * LEFT_Y[c.pivot], ROT_SHIFT);
          vy = -trunc_shr(om * LEFT_X[c.pivot], ROT_SHIFT);
        end
        CMD_TURN_RIGHT: begin
          w  = -s;
          om = w * longint'(set_irs);
          vx = trunc_shr(om * RIGHT_Y[c.pivot], ROT_SHIFT);
          vy = -trunc_shr(om * RIGHT_X[c.pivot], ROT_SHIFT);
        end
        default: ;
      endcase
      wh[0] = trunc_shr((vy - vx - w) * sc[0], 8);
      wh[1] = trunc_shr((vy + vx + w) * sc[1], 8);
      wh[2] = trunc_shr((vy + vx - w) * sc[2], 8);
      wh[3] = trunc_shr((vy - vx + w) * sc[3], 8);
    end
    r.fl = wheel_duty(wh[0], 0);
    r.fr = wheel_duty(wh[1], 1);
    r.rl = wheel_duty(wh[2], 2);
    r.rr = wheel_duty(wh[3], 3);
    return r;
  endfunction

  function automatic drive_cmd_t cmd_of(cmd_e op, int spd, logic [2:0] pv,
                                        int fl, int fr, int rl, int rr);
    drive_cmd_t c;
    c.op    = op;
    c.speed = 16'(spd);
    c.pivot = pv;
    c.tfl   = 16'(fl);
    c.tfr   = 16'(fr);
    c.trl   = 16'(rl);
    c.trr   = 16'(rr);
    return c;
  endfunction

  function automatic duty_set_t duty_of(int fl, int fr, int rl, int rr, logic b);
    duty_set_t d;
    d.fl    = (DUTY_W + 1)'(fl);
    d.fr    = (DUTY_W + 1)'(fr);
    d.rl    = (DUTY_W + 1)'(rl);
    d.rr    = (DUTY_W + 1)'(rr);
    d.brake = b;
    return d;
  endfunction

  // Mix of extremes, small speeds of at most 8191 either way, and full range
  function automatic int rand_speed();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 4))
        0: return -32768;
        1: return 32767;
        2: return 0;
        3: return 1;
        default: return -1;
      endcase
    end
    if (pick <= 4)
      return $urandom_range(0, 1) ? int'($urandom_range(0, 8191)) :
                                    -int'($urandom_range(0, 8191));
    return int'(signed'(16'($urandom)));
  endfunction

  function automatic drive_cmd_t rand_cmd();
    return cmd_of(cmd_e'($urandom_range(0, 7)), rand_speed(), 3'($urandom_range(0, 7)),
                  rand_speed(), rand_speed(), rand_speed(), rand_speed());
  endfunction

  // Present one item, with a random gap in front, and hold it until taken
  task automatic send_cmd(drive_cmd_t c, logic typed, duty_set_t want);
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    cmd              <= c.op;
    speed            <= c.speed;
    pivot            <= c.pivot;
    test_front_left  <= c.tfl;
    test_front_right <= c.tfr;
    test_rear_left   <= c.trl;
    test_rear_right  <= c.trr;
    row_typed        <= typed;
    row_want         <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // Drop valid and let the pipeline drain before touching the registers;
  // first wait for the next edge, so the item taken at the last edge is already logged
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (duty_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all five registers back to back, then release the write enable
  task automatic apply_setting(logic [15:0] dps, logic [15:0] mn, logic [15:0] mx,
                               logic [15:0] pol, logic [15:0] irs);
    logic [15:0] vals [5];
    vals = '{dps, mn, mx, pol, irs};
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      case (CFG_IDX_W'(i))
        REG_DUTY_PER_SPEED:      set_dps = vals[i];
        REG_MIN_ACTIVE_DUTY:     set_min = vals[i][9:0];
        REG_MAX_DUTY:            set_max = vals[i][9:0];
        REG_WHEEL_POLARITY_MASK: set_pol = vals[i][3:0];
        REG_INVERSE_RADIUS_SUM:  set_irs = vals[i];
        default: ;
      endcase
    end
    cfg_write <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  task automatic check_field(string name, logic signed [DUTY_W:0] want,
                             logic signed [DUTY_W:0] got);
    if (got !== want) begin
      n_faults++;
      if (n_faults <= 10)
        $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // Scoreboard: score leaving duty sets first, then log the item taken this edge
  always @(posedge clk) begin : score
    duty_set_t  want;
    drive_cmd_t seen;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (duty_q.size() == 0) begin
          n_faults++;
          if (n_faults <= 10)
            $display("%0t: duty set with nothing outstanding: %0d %0d %0d %0d brake %0b",
                     $realtime, duty_front_left, duty_front_right, duty_rear_left,
                     duty_rear_right, brake);
        end else begin
          want = duty_q.pop_front();
          n_checked++;
          check_field("duty_front_left", want.fl, duty_front_left);
          check_field("duty_front_right", want.fr, duty_front_right);
          check_field("duty_rear_left", want.rl, duty_rear_left);
          check_field("duty_rear_right", want.rr, duty_rear_right);
          check_field("brake", (DUTY_W + 1)'(want.brake), (DUTY_W + 1)'(brake));
        end
      end
      if (in_valid && in_ready) begin
        seen.op    = cmd_e'(cmd);
        seen.speed = speed;
        seen.pivot = pivot;
        seen.tfl   = test_front_left;
        seen.tfr   = test_front_right;
        seen.trl   = test_rear_left;
        seen.trr   = test_rear_right;
        duty_q.push_back(row_typed ? row_want : mix_duties(seen));
      end
    end
  end

  // Receiver: hold ready low in random bursts, except in the closing stretch
  initial begin : sink
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] r_dps;
    logic [15:0] r_min;
    logic [15:0] r_max;
    logic [15:0] r_pol;
    logic [15:0] r_irs;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows under the reset settings; the first eight, clamped results among them, are typed in
    cmd_table.push_back('{cmd_of(CMD_STOP, 32767, PIVOT_FRONT, 100, -100, 100, -100),
                          1'b1, duty_of(0, 0, 0, 0, 1'b1)});
    cmd_table.push_back('{cmd_of(CMD_FORWARD, 0, PIVOT_FRONT, 0, 0, 0, 0),
                          1'b1, duty_of(0, 0, 0, 0, 1'b0)});
    cmd_table.push_back('{cmd_of(CMD_FORWARD, 32767, PIVOT_FRONT, 0, 0, 0, 0),
                          1'b1, duty_of(1000, 1000, 1000, 1000, 1'b0)});
    cmd_table.push_back('{cmd_of(CMD_FORWARD, -32768, PIVOT_FRONT, 0, 0, 0, 0),
                          1'b1, duty_of(-1000, -1000, -1000, -1000, 1'b0)});
    cmd_table.push_back('{cmd_of(CMD_REVERSE, 32767, PIVOT_FRONT, 0, 0, 0, 0),
                          1'b1, duty_of(-1000, -1000, -1000, -1000, 1'b0)});
    cmd_table.push_back('{cmd_of(CMD_STRAFE_RIGHT, 32767, PIVOT_FRONT, 0, 0, 0, 0),
                          1'b1, duty_of(1000, -1000, -1000, 1000, 1'b0)});
    cmd_table.push_back('{cmd_of(CMD_STRAFE_LEFT, 32767, PIVOT_FRONT, 0, 0, 0, 0),
                          1'b1, duty_of(-1000, 1000, 1000, -1000, 1'b0)});
    cmd_table.push_back('{cmd_of(CMD_WHEEL_TEST, 0, PIVOT_FRONT, 256, -256, 0, 32767),
                          1'b1, duty_of(10, -10, 0, 1000, 1'b0)});
    // wheel test at the field extremes and with wheel speeds too small to give any duty, then a forward row
    cmd_table.push_back('{cmd_of(CMD_WHEEL_TEST, 0, PIVOT_FRONT, -32768, 32767, 1, -1),
                          1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_FORWARD, 1000, PIVOT_FRONT, 0, 0, 0, 0),
                          1'b0, NO_DUTY});
    // turns about every named pivot and two out-of-range ones, in both directions
    cmd_table.push_back('{cmd_of(CMD_TURN_LEFT, 1000, PIVOT_FRONT, 0, 0, 0, 0), 1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_TURN_LEFT, 1000, PIVOT_BACK, 0, 0, 0, 0), 1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_TURN_LEFT, 1000, PIVOT_LEFT, 0, 0, 0, 0), 1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_TURN_LEFT, 1000, PIVOT_RIGHT, 0, 0, 0, 0), 1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_TURN_LEFT, 1000, PIVOT_CENTER, 0, 0, 0, 0), 1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_TURN_LEFT, 1000, PIVOT_OUT_LO, 0, 0, 0, 0), 1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_TURN_RIGHT, -1500, PIVOT_FRONT, 0, 0, 0, 0), 1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_TURN_RIGHT, -1500, PIVOT_BACK, 0, 0, 0, 0), 1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_TURN_RIGHT, -1500, PIVOT_LEFT, 0, 0, 0, 0), 1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_TURN_RIGHT, -1500, PIVOT_RIGHT, 0, 0, 0, 0), 1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_TURN_RIGHT, -1500, PIVOT_CENTER, 0, 0, 0, 0),
                          1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_TURN_RIGHT, -1500, PIVOT_OUT_HI, 0, 0, 0, 0),
                          1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_TURN_LEFT, -32768, PIVOT_FRONT, 0, 0, 0, 0),
                          1'b0, NO_DUTY});
    cmd_table.push_back('{cmd_of(CMD_TURN_RIGHT, 32767, PIVOT_BACK, 0, 0, 0, 0),
                          1'b0, NO_DUTY});

    foreach (cmd_table[i])
      send_cmd(cmd_table[i].c, cmd_table[i].typed, cmd_table[i].want);

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: apply_setting(16'd2560, 16'd5, 16'd1000, 16'b1010, 16'd6554);
        1: apply_setting(16'hFFFF, 16'd1023, 16'd1023, 16'hF, 16'hFFFF);
        2: apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        // minimum above maximum: the clamp wins
        3: apply_setting(16'd2560, 16'd800, 16'd300, 16'b0110, 16'd6554);
        PHASES - 1: apply_setting(16'd2560, 16'd20, 16'd1000, 16'b1001, 16'd6554);
        default: begin
          // junk in the unused upper data bits must be dropped by the block
          r_dps = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4095));
          r_min = {6'($urandom), $urandom_range(0, 1) ? 10'($urandom_range(0, 63))
                                                      : 10'($urandom)};
          r_max = {6'($urandom), 10'($urandom)};
          r_pol = 16'($urandom);
          r_irs = 16'($urandom);
          apply_setting(r_dps, r_min, r_max, r_pol, r_irs);
        end
      endcase
      gap_odds = $urandom_range(0, 4);
      // closing stretch runs flat out on both sides
      quiet = (p == PHASES - 1);
      repeat (PHASE_ITEMS)
        send_cmd(rand_cmd(), 1'b0, NO_DUTY);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (duty_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (duty_q.size() != 0)
      n_faults += duty_q.size();

    $display("Coverage: %0d commands sent over %0d register settings, %0d duty sets scored",
             n_sent, n_settings, n_checked);
    $display("Mismatches and stray or missing duty sets: %0d", n_faults);
    if (n_faults == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/mdcm_pkg.sv
src/mdcm_kin.sv
src/mdcm_trim.sv
src/mdcm_duty.sv
src/mecanum_drive_command_mixer.sv
test/tb_top.sv
